[hdl/spmq_pkg.sv]
// shared types and codes for the shared-pool message queues
package spmq_pkg;

   localparam logic [1:0] CMD_SEND = 2'd0;
   localparam logic [1:0] CMD_READ = 2'd1;

   localparam logic [1:0] STAT_DONE  = 2'd0;
   localparam logic [1:0] STAT_FULL  = 2'd1;
   localparam logic [1:0] STAT_EMPTY = 2'd2;

   localparam int NEAR_MARGIN = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic issue;
      logic commit;
   } ctl_cmd_type;

   typedef struct packed {
      logic last_addr;
   } ctl_stat_type;

endpackage

[hdl/spmq_ctrl.sv]
// sequencer for the slot scan and the commit step
module spmq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  spmq_pkg::ctl_stat_type ctl_stat,
   output spmq_pkg::ctl_cmd_type  ctl_cmd
);
   import spmq_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      ctl_cmd.start  = 1'b0;
      ctl_cmd.issue  = 1'b0;
      ctl_cmd.commit = 1'b0;
      req_stall      = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl_cmd.start = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            ctl_cmd.issue = 1'b1;
            if (ctl_stat.last_addr) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last slot row is folded in at this edge
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               ctl_cmd.commit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = ctl_cmd.commit | (rsp_valid_ff & rsp_stall);
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

[hdl/spmq_datapath.sv]
// slot store, scan accumulators, counters and result register
module spmq_datapath #(
   parameter int SLOTS       = 16,
   parameter int DATA_BITS   = 64,
   parameter int HANDLE_BITS = 8,
   parameter int SEQ_BITS    = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  spmq_pkg::ctl_cmd_type        ctl_cmd,
   output spmq_pkg::ctl_stat_type       ctl_stat,
   input  logic [1:0]                   req_command,
   input  logic [HANDLE_BITS-1:0]       req_handle,
   input  logic [DATA_BITS-1:0]         req_msg_data,
   output logic [1:0]                   rsp_status,
   output logic [DATA_BITS-1:0]         rsp_read_data,
   output logic [$clog2(SLOTS+1)-1:0]   rsp_msg_count,
   output logic [$clog2(SLOTS+1)-1:0]   rsp_slots_used,
   output logic [$clog2(SLOTS+1)-1:0]   rsp_slots_used_peak,
   output logic                         rsp_nearly_full
);
   import spmq_pkg::*;

   localparam int IDX_BITS = $clog2(SLOTS);
   localparam int CNT_BITS = $clog2(SLOTS+1);
   localparam int ROW_BITS = HANDLE_BITS + SEQ_BITS + DATA_BITS;

   // slot rows: owner, sequence, message
   logic [ROW_BITS-1:0]    mem [SLOTS];
   logic [ROW_BITS-1:0]    row_ff;
   logic [SLOTS-1:0]       slot_valid_ff;
   logic [SLOTS-1:0]       slot_valid_in;

   logic [1:0]             cmd_ff;
   logic [HANDLE_BITS-1:0] handle_ff;
   logic [DATA_BITS-1:0]   data_ff;

   logic [IDX_BITS-1:0]    scan_idx_ff;
   logic [IDX_BITS-1:0]    scan_idx_in;
   logic                   pend_ff;
   logic [IDX_BITS-1:0]    pend_idx_ff;
   logic                   pend_valid_ff;

   logic [CNT_BITS-1:0]    cnt_ff,         cnt_in;
   logic                   free_found_ff,  free_found_in;
   logic [IDX_BITS-1:0]    free_idx_ff,    free_idx_in;
   logic [SEQ_BITS-1:0]    max_seq_ff,     max_seq_in;
   logic                   pick_found_ff,  pick_found_in;
   logic [IDX_BITS-1:0]    pick_idx_ff,    pick_idx_in;
   logic [SEQ_BITS-1:0]    pick_seq_ff,    pick_seq_in;
   logic [DATA_BITS-1:0]   pick_data_ff,   pick_data_in;

   logic [CNT_BITS-1:0]    used_ff,        used_in;
   logic [CNT_BITS-1:0]    peak_ff,        peak_in;

   logic [1:0]             status_in;
   logic [DATA_BITS-1:0]   read_data_in;
   logic [CNT_BITS-1:0]    msg_count_in;
   logic                   nearly_full_in;

   logic [1:0]             status_ff;
   logic [DATA_BITS-1:0]   read_data_ff;
   logic [CNT_BITS-1:0]    msg_count_ff;
   logic [CNT_BITS-1:0]    slots_used_ff;
   logic [CNT_BITS-1:0]    slots_used_peak_ff;
   logic                   nearly_full_ff;

   logic [HANDLE_BITS-1:0] row_owner;
   logic [SEQ_BITS-1:0]    row_seq;
   logic [DATA_BITS-1:0]   row_msg;
   logic                   row_match;
   logic                   send_ok;
   logic                   read_ok;
   logic [ROW_BITS-1:0]    new_row;

   assign row_owner = row_ff[ROW_BITS-1 -: HANDLE_BITS];
   assign row_seq   = row_ff[DATA_BITS +: SEQ_BITS];
   assign row_msg   = row_ff[DATA_BITS-1:0];
   assign row_match = pend_ff && pend_valid_ff && (row_owner == handle_ff);

   assign send_ok = (cmd_ff == CMD_SEND) && free_found_ff;
   assign read_ok = (cmd_ff == CMD_READ) && pick_found_ff;
   assign new_row = {handle_ff, max_seq_ff + SEQ_BITS'(1), data_ff};

   assign ctl_stat.last_addr = (scan_idx_ff == IDX_BITS'(SLOTS-1));

   // per-slot fold of count, first free slot, newest and oldest of the handle
   always_comb begin
      scan_idx_in   = scan_idx_ff;
      cnt_in        = cnt_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      max_seq_in    = max_seq_ff;
      pick_found_in = pick_found_ff;
      pick_idx_in   = pick_idx_ff;
      pick_seq_in   = pick_seq_ff;
      pick_data_in  = pick_data_ff;
      if (ctl_cmd.start) begin
         scan_idx_in   = '0;
         cnt_in        = '0;
         free_found_in = 1'b0;
         max_seq_in    = '0;
         pick_found_in = 1'b0;
      end else begin
         if (ctl_cmd.issue) begin
            scan_idx_in = scan_idx_ff + IDX_BITS'(1);
         end
         if (pend_ff && !pend_valid_ff && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = pend_idx_ff;
         end
         if (row_match) begin
            cnt_in = cnt_ff + CNT_BITS'(1);
            if (row_seq > max_seq_ff) begin
               max_seq_in = row_seq;
            end
            if (!pick_found_ff || (row_seq < pick_seq_ff)) begin
               pick_found_in = 1'b1;
               pick_idx_in   = pend_idx_ff;
               pick_seq_in   = row_seq;
               pick_data_in  = row_msg;
            end
         end
      end
   end

   // commit step
   always_comb begin
      slot_valid_in = slot_valid_ff;
      used_in       = used_ff;
      status_in     = STAT_DONE;
      read_data_in  = '0;
      msg_count_in  = cnt_ff;
      if (cmd_ff == CMD_SEND) begin
         if (free_found_ff) begin
            slot_valid_in[free_idx_ff] = 1'b1;
            used_in                    = used_ff + CNT_BITS'(1);
            msg_count_in               = cnt_ff + CNT_BITS'(1);
         end else begin
            status_in = STAT_FULL;
         end
      end else if (cmd_ff == CMD_READ) begin
         if (pick_found_ff) begin
            slot_valid_in[pick_idx_ff] = 1'b0;
            read_data_in               = pick_data_ff;
            msg_count_in               = cnt_ff - CNT_BITS'(1);
            if (used_ff != '0) begin
               used_in = used_ff - CNT_BITS'(1);
            end
         end else begin
            status_in = STAT_EMPTY;
         end
      end
      peak_in = (send_ok && (used_in > peak_ff)) ? used_in : peak_ff;
      nearly_full_in = (used_in >= CNT_BITS'(SLOTS - NEAR_MARGIN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
         used_ff       <= '0;
         peak_ff       <= '0;
         pend_ff       <= 1'b0;
         scan_idx_ff   <= '0;
         free_found_ff <= 1'b0;
         pick_found_ff <= 1'b0;
      end else begin
         pend_ff       <= ctl_cmd.issue;
         scan_idx_ff   <= scan_idx_in;
         free_found_ff <= free_found_in;
         pick_found_ff <= pick_found_in;
         if (ctl_cmd.commit) begin
            slot_valid_ff <= slot_valid_in;
            used_ff       <= used_in;
            peak_ff       <= peak_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.start) begin
         cmd_ff    <= req_command;
         handle_ff <= req_handle;
         data_ff   <= req_msg_data;
      end
      if (ctl_cmd.issue) begin
         pend_idx_ff   <= scan_idx_ff;
         pend_valid_ff <= slot_valid_ff[scan_idx_ff];
      end
      cnt_ff       <= cnt_in;
      free_idx_ff  <= free_idx_in;
      max_seq_ff   <= max_seq_in;
      pick_idx_ff  <= pick_idx_in;
      pick_seq_ff  <= pick_seq_in;
      pick_data_ff <= pick_data_in;
      if (ctl_cmd.commit) begin
         status_ff          <= status_in;
         read_data_ff       <= read_data_in;
         msg_count_ff       <= msg_count_in;
         slots_used_ff      <= used_in;
         slots_used_peak_ff <= peak_in;
         nearly_full_ff     <= nearly_full_in;
      end
   end

   // slot memory, one write port and one registered read port
   always_ff @(posedge clock) begin
      if (ctl_cmd.commit && send_ok) begin
         mem[free_idx_ff] <= new_row;
      end
      if (ctl_cmd.issue) begin
         row_ff <= mem[scan_idx_ff];
      end
   end

   assign rsp_status          = status_ff;
   assign rsp_read_data       = read_data_ff;
   assign rsp_msg_count       = msg_count_ff;
   assign rsp_slots_used      = slots_used_ff;
   assign rsp_slots_used_peak = slots_used_peak_ff;
   assign rsp_nearly_full     = nearly_full_ff;

endmodule

[hdl/shared_pool_message_queues.sv]
// top level: message queues that share one pool of slots
// each item scans every slot once, one slot per cycle through the slot memory read port
// items are taken one at a time: a new item is accepted only in idle, after the last one has committed
// the result register lets the next item be accepted while a result waits to be taken
// synchronous active-high reset frees all slots and clears occupancy and peak, no sweep needed
module shared_pool_message_queues #(
   parameter int SLOTS       = 16,
   parameter int DATA_BITS   = 64,
   parameter int HANDLE_BITS = 8,
   parameter int SEQ_BITS    = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_command,
   input  logic [HANDLE_BITS-1:0]       req_handle,
   input  logic [DATA_BITS-1:0]         req_msg_data,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [1:0]                   rsp_status,
   output logic [DATA_BITS-1:0]         rsp_read_data,
   output logic [$clog2(SLOTS+1)-1:0]   rsp_msg_count,
   output logic [$clog2(SLOTS+1)-1:0]   rsp_slots_used,
   output logic [$clog2(SLOTS+1)-1:0]   rsp_slots_used_peak,
   output logic                         rsp_nearly_full
);
   import spmq_pkg::*;

   ctl_cmd_type  ctl_cmd;
   ctl_stat_type ctl_stat;

   spmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl_stat  (ctl_stat),
      .ctl_cmd   (ctl_cmd)
   );

   spmq_datapath #(
      .SLOTS       (SLOTS),
      .DATA_BITS   (DATA_BITS),
      .HANDLE_BITS (HANDLE_BITS),
      .SEQ_BITS    (SEQ_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .ctl_cmd             (ctl_cmd),
      .ctl_stat            (ctl_stat),
      .req_command         (req_command),
      .req_handle          (req_handle),
      .req_msg_data        (req_msg_data),
      .rsp_status          (rsp_status),
      .rsp_read_data       (rsp_read_data),
      .rsp_msg_count       (rsp_msg_count),
      .rsp_slots_used      (rsp_slots_used),
      .rsp_slots_used_peak (rsp_slots_used_peak),
      .rsp_nearly_full     (rsp_nearly_full)
   );

endmodule

[hdl/spmq_checker.sv]
// port-level checks for the shared-pool message queues, bound to the top level
module spmq_checker #(
   parameter int SLOTS       = 16,
   parameter int DATA_BITS   = 64,
   parameter int HANDLE_BITS = 8,
   parameter int SEQ_BITS    = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic [1:0]                   req_command,
   input logic [HANDLE_BITS-1:0]       req_handle,
   input logic [DATA_BITS-1:0]         req_msg_data,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [1:0]                   rsp_status,
   input logic [DATA_BITS-1:0]         rsp_read_data,
   input logic [$clog2(SLOTS+1)-1:0]   rsp_msg_count,
   input logic [$clog2(SLOTS+1)-1:0]   rsp_slots_used,
   input logic [$clog2(SLOTS+1)-1:0]   rsp_slots_used_peak,
   input logic                         rsp_nearly_full
);
   import spmq_pkg::*;

   localparam int CNT_BITS = $clog2(SLOTS+1);

   // a waiting result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_read_data) && $stable(rsp_slots_used))
      else $error("result changed while stalled");

   a_peak: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_slots_used_peak >= rsp_slots_used)
      else $error("peak below occupancy");

   a_near: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_nearly_full == (rsp_slots_used >= CNT_BITS'(SLOTS - NEAR_MARGIN)))
      else $error("nearly full flag wrong");

   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_FULL |->
         rsp_slots_used == CNT_BITS'(SLOTS) && rsp_read_data == '0)
      else $error("full status with free slots");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STAT_EMPTY |-> rsp_read_data == '0 && rsp_msg_count == '0)
      else $error("empty status with messages");

endmodule

bind shared_pool_message_queues spmq_checker #(
   .SLOTS       (SLOTS),
   .DATA_BITS   (DATA_BITS),
   .HANDLE_BITS (HANDLE_BITS),
   .SEQ_BITS    (SEQ_BITS)
) u_spmq_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_stall           (req_stall),
   .req_command         (req_command),
   .req_handle          (req_handle),
   .req_msg_data        (req_msg_data),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_status          (rsp_status),
   .rsp_read_data       (rsp_read_data),
   .rsp_msg_count       (rsp_msg_count),
   .rsp_slots_used      (rsp_slots_used),
   .rsp_slots_used_peak (rsp_slots_used_peak),
   .rsp_nearly_full     (rsp_nearly_full)
);

[bench/spmq_reply_checker.sv]
// checker for the shared-pool message queues: tracks the pool, predicts and compares each reply
module spmq_reply_checker #(
   parameter int SLOTS       = 16,
   parameter int DATA_BITS   = 64,
   parameter int HANDLE_BITS = 8,
   parameter int SEQ_BITS    = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [1:0]                   req_command,
   input  logic [HANDLE_BITS-1:0]       req_handle,
   input  logic [DATA_BITS-1:0]         req_msg_data,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [1:0]                   rsp_status,
   input  logic [DATA_BITS-1:0]         rsp_read_data,
   input  logic [$clog2(SLOTS+1)-1:0]   rsp_msg_count,
   input  logic [$clog2(SLOTS+1)-1:0]   rsp_slots_used,
   input  logic [$clog2(SLOTS+1)-1:0]   rsp_slots_used_peak,
   input  logic                         rsp_nearly_full,
   output int                           mismatches,
   output int                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import spmq_pkg::*;

   localparam int CW = $clog2(SLOTS + 1);

   typedef struct packed {
      logic [1:0]           status;
      logic [DATA_BITS-1:0] read_data;
      logic [CW-1:0]        msg_count;
      logic [CW-1:0]        slots_used;
      logic [CW-1:0]        slots_used_peak;
      logic                 nearly_full;
   } queue_reply_type;

   // own copy of the pool
   logic                   slot_busy  [SLOTS];
   logic [HANDLE_BITS-1:0] slot_queue [SLOTS];
   logic [SEQ_BITS-1:0]    slot_seq   [SLOTS];
   logic [DATA_BITS-1:0]   slot_word  [SLOTS];
   logic [CW-1:0]          occupancy;
   logic [CW-1:0]          occupancy_peak;

   queue_reply_type replies_due[$];

   function automatic queue_reply_type apply_command(input logic [1:0] cmd,
                                                     input logic [HANDLE_BITS-1:0] h,
                                                     input logic [DATA_BITS-1:0] data);
      queue_reply_type r;
      logic [SEQ_BITS-1:0] top_seq;
      int free_slot;
      int pick;
      int held;
      r = '0;
      top_seq = '0;
      free_slot = -1;
      pick = -1;
      held = 0;
      if (cmd == CMD_SEND) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_busy[i] && slot_queue[i] == h && slot_seq[i] > top_seq)
               top_seq = slot_seq[i];
            if (!slot_busy[i] && free_slot < 0)
               free_slot = i;
         end
         if (free_slot < 0) begin
            r.status = STAT_FULL;
         end else begin
            slot_busy[free_slot]  = 1'b1;
            slot_queue[free_slot] = h;
            // truncation to SEQ_BITS gives the wrap
            slot_seq[free_slot]   = top_seq + 1'b1;
            slot_word[free_slot]  = data;
            occupancy = occupancy + 1'b1;
            if (occupancy > occupancy_peak)
               occupancy_peak = occupancy;
         end
      end else if (cmd == CMD_READ) begin
         for (int i = 0; i < SLOTS; i++) begin
            if (slot_busy[i] && slot_queue[i] == h) begin
               if (pick < 0 || slot_seq[i] < slot_seq[pick])
                  pick = i;
            end
         end
         if (pick < 0) begin
            r.status = STAT_EMPTY;
         end else begin
            r.read_data      = slot_word[pick];
            slot_busy[pick]  = 1'b0;
            slot_queue[pick] = '0;
            slot_seq[pick]   = '0;
            slot_word[pick]  = '0;
            if (occupancy > 0)
               occupancy = occupancy - 1'b1;
         end
      end
      // any other code is a count and changes nothing
      for (int i = 0; i < SLOTS; i++)
         if (slot_busy[i] && slot_queue[i] == h)
            held++;
      r.msg_count       = CW'(held);
      r.slots_used      = occupancy;
      r.slots_used_peak = occupancy_peak;
      r.nearly_full     = (occupancy >= SLOTS - NEAR_MARGIN);
      return r;
   endfunction

   always @(posedge clock) begin
      queue_reply_type want;
      queue_reply_type got;
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_busy[i]  = 1'b0;
            slot_queue[i] = '0;
            slot_seq[i]   = '0;
            slot_word[i]  = '0;
         end
         occupancy = '0;
         occupancy_peak = '0;
         replies_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got.status          = rsp_status;
            got.read_data       = rsp_read_data;
            got.msg_count       = rsp_msg_count;
            got.slots_used      = rsp_slots_used;
            got.slots_used_peak = rsp_slots_used_peak;
            got.nearly_full     = rsp_nearly_full;
            if (replies_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: reply with no item waiting: status=%0d data=%h", $realtime,
                           got.status, got.read_data);
            end else begin
               want = replies_due.pop_front();
               if (got.status !== want.status || got.read_data !== want.read_data ||
                   got.msg_count !== want.msg_count || got.slots_used !== want.slots_used ||
                   got.slots_used_peak !== want.slots_used_peak ||
                   got.nearly_full !== want.nearly_full) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t: reply differs", $realtime);
                     $display("  expected status=%0d data=%h count=%0d used=%0d peak=%0d near=%0d",
                              want.status, want.read_data, want.msg_count, want.slots_used,
                              want.slots_used_peak, want.nearly_full);
                     $display("  actual   status=%0d data=%h count=%0d used=%0d peak=%0d near=%0d",
                              got.status, got.read_data, got.msg_count, got.slots_used,
                              got.slots_used_peak, got.nearly_full);
                  end
               end
            end
         end
         if (req_valid && !req_stall)
            replies_due.push_back(apply_command(req_command, req_handle, req_msg_data));
      end
      outstanding = replies_due.size();
   end

endmodule

[bench/shared_pool_message_queues_tb.sv]
// testbench top for the shared-pool message queues: clock, reset, items, reply taking, verdict
module shared_pool_message_queues_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spmq_pkg::*;

   localparam int SLOTS       = 16;
   localparam int DATA_BITS   = 64;
   localparam int HANDLE_BITS = 8;
   localparam int SEQ_BITS    = 32;
   localparam int CW          = $clog2(SLOTS + 1);

   localparam logic [1:0] CMD_COUNT     = 2'd2;
   localparam logic [1:0] CMD_COUNT_ALT = 2'd3;

   localparam int RANDOM_ITEMS = 400;
   localparam int PHASE_ITEMS  = 40;
   localparam int MAX_WAIT     = 16;
   localparam int HOLD_AT      = 150;
   localparam int LONG_HOLD    = 600;
   localparam int CYCLE_LIMIT  = 200000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [1:0]             req_command = CMD_COUNT;
   logic [HANDLE_BITS-1:0] req_handle = '0;
   logic [DATA_BITS-1:0]   req_msg_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [1:0]             rsp_status;
   logic [DATA_BITS-1:0]   rsp_read_data;
   logic [CW-1:0]          rsp_msg_count;
   logic [CW-1:0]          rsp_slots_used;
   logic [CW-1:0]          rsp_slots_used_peak;
   logic                   rsp_nearly_full;

   int mismatches;
   int outstanding;
   int send_quiet = 0;
   int take_quiet = 0;
   int cycle_count = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   shared_pool_message_queues #(
      .SLOTS(SLOTS), .DATA_BITS(DATA_BITS), .HANDLE_BITS(HANDLE_BITS), .SEQ_BITS(SEQ_BITS)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_handle(req_handle), .req_msg_data(req_msg_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_read_data(rsp_read_data), .rsp_msg_count(rsp_msg_count),
      .rsp_slots_used(rsp_slots_used), .rsp_slots_used_peak(rsp_slots_used_peak),
      .rsp_nearly_full(rsp_nearly_full)
   );

   spmq_reply_checker #(
      .SLOTS(SLOTS), .DATA_BITS(DATA_BITS), .HANDLE_BITS(HANDLE_BITS), .SEQ_BITS(SEQ_BITS)
   ) u_reply_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_command(req_command),
      .req_handle(req_handle), .req_msg_data(req_msg_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_read_data(rsp_read_data), .rsp_msg_count(rsp_msg_count),
      .rsp_slots_used(rsp_slots_used), .rsp_slots_used_peak(rsp_slots_used_peak),
      .rsp_nearly_full(rsp_nearly_full),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   // random wait with occasional stretches of no idling
   function automatic int draw_wait(inout int quiet_left);
      if (quiet_left > 0) begin
         quiet_left--;
         return 0;
      end
      if ($urandom_range(0, 19) == 0) begin
         quiet_left = $urandom_range(8, 40);
         return 0;
      end
      return $urandom_range(0, MAX_WAIT);
   endfunction

   task automatic push_item(input logic [1:0] cmd, input logic [HANDLE_BITS-1:0] h,
                            input logic [DATA_BITS-1:0] data);
      int gap;
      gap = draw_wait(send_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_handle   <= h;
      req_msg_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   initial begin
      logic [HANDLE_BITS-1:0] hot [4];
      logic [HANDLE_BITS-1:0] h;
      logic [DATA_BITS-1:0]   data;
      logic [1:0]             cmd;
      int                     roll;
      bit                     filling;
      filling = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // empty queues at both handle extremes, then sends and reads on them
      push_item(CMD_COUNT, '0, '0);
      push_item(CMD_READ, '0, {$urandom, $urandom});
      push_item(CMD_READ, '1, '1);
      push_item(CMD_COUNT_ALT, '1, '1);
      push_item(CMD_SEND, '0, '0);
      push_item(CMD_SEND, '1, '1);
      push_item(CMD_SEND, '0, {32{2'b01}});
      push_item(CMD_SEND, '1, {32{2'b10}});
      push_item(CMD_READ, '0, '1);
      push_item(CMD_COUNT, '1, '0);
      // fill the pool through nearly full up to full, then send into the full pool and read back
      for (int k = 0; k < SLOTS - 3; k++)
         push_item(CMD_SEND, 8'h5A, {$urandom, $urandom});
      push_item(CMD_SEND, 8'hA5, {$urandom, $urandom});
      push_item(CMD_COUNT_ALT, 8'h5A, {$urandom, $urandom});
      push_item(CMD_READ, 8'h5A, '0);
      push_item(CMD_READ, 8'hA5, '0);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) begin
            filling = ~filling;
            for (int i = 0; i < 4; i++)
               hot[i] = HANDLE_BITS'($urandom_range(0, 255));
         end
         roll = $urandom_range(0, 99);
         if (roll < (filling ? 60 : 25))
            cmd = CMD_SEND;
         else if (roll < (filling ? 85 : 80))
            cmd = CMD_READ;
         else
            cmd = ($urandom_range(0, 3) == 0) ? CMD_COUNT_ALT : CMD_COUNT;
         // mostly a few busy queues so they get deep, some stray handles
         if ($urandom_range(0, 99) < 85)
            h = hot[$urandom_range(0, 3)];
         else
            h = HANDLE_BITS'($urandom_range(0, 255));
         roll = $urandom_range(0, 9);
         if (roll == 0)
            data = '0;
         else if (roll == 1)
            data = '1;
         else
            data = {$urandom, $urandom};
         push_item(cmd, h, data);
      end
      req_valid <= 1'b0;

      do @(negedge clock); while (outstanding != 0);
      repeat (SLOTS + 8) @(negedge clock);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // reply taker, with one long hold-off so the block backs up into its input
   initial begin
      int  n;
      int  taken;
      bit  held;
      taken = 0;
      held = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AT && !held) begin
            n = LONG_HOLD;
            held = 1'b1;
         end else begin
            n = draw_wait(take_quiet);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("end of test: mismatches");
      $finish;
   end

endmodule
